// ===== sv/tmav_pkg.sv =====
// Shared types, constants and helpers for the tilt-to-servo moving average.
// Used by tmav_cell, tmav_scale and tilt_to_servo_moving_average.
`timescale 1ns / 1ps

package tmav_pkg;

   localparam int WINDOW    = 50;
   localparam int ONE_G_LOG2 = 13;
   localparam int ONE_G     = 1 << ONE_G_LOG2;

   localparam int ACCEL_W   = 16;
   localparam int SAMPLE_W  = ONE_G_LOG2 + 2;
   localparam int SUM_W     = $clog2(WINDOW * ONE_G + 1) + 1;
   localparam int GAIN_W    = 10;
   localparam int OFS_W     = 16;
   localparam int PULSE_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // sum * gain, gain taken as a positive signed operand
   localparam int PROD_W    = SUM_W + GAIN_W + 1;
   // floor(prod / 2^13) lies within +/- 1023 * WINDOW; biased by 1024 * WINDOW
   localparam int QBIAS     = 1 << GAIN_W;
   localparam int BIAS      = QBIAS * WINDOW;
   localparam int U_W       = $clog2(2 * QBIAS * WINDOW);
   // floor(u / WINDOW) as (u * RECIP) >> RECIP_SHIFT, exact for u < 2048 * WINDOW
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP     = ((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int RECIP_W   = RECIP_SHIFT + 1;
   localparam int RPROD_W   = U_W + RECIP_W;
   localparam int QUOT_W    = GAIN_W + 1;
   localparam int RES_W     = OFS_W + 2;

   localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(254);
   localparam logic [OFS_W-1:0]  X_OFFSET_RESET = OFS_W'(762);
   localparam logic [OFS_W-1:0]  Y_OFFSET_RESET = OFS_W'(768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN     = 2'd0,
      CSR_X_OFFSET = 2'd1,
      CSR_Y_OFFSET = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic ld_prod;
      logic ld_quot;
      logic ld_out;
   } pipe_ctl_type;

   // Clamp a raw sample to +/- one g.
   function automatic logic signed [SAMPLE_W-1:0] clamp_sample(
      input logic signed [ACCEL_W-1:0] raw
   );
      logic signed [ACCEL_W-1:0] lim_hi;
      logic signed [ACCEL_W-1:0] lim_lo;
      lim_hi = ACCEL_W'(ONE_G);
      lim_lo = -ACCEL_W'(ONE_G);
      if (raw > lim_hi) begin
         return SAMPLE_W'(ONE_G);
      end else if (raw < lim_lo) begin
         return -SAMPLE_W'(ONE_G);
      end else begin
         return raw[SAMPLE_W-1:0];
      end
   endfunction

endpackage

// ===== sv/tmav_cell.sv =====
// One window cell: holds one clamped X and Y sample and passes it on per beat.
// Depends on tmav_pkg.
`timescale 1ns / 1ps

module tmav_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  shift,
   input  logic signed [tmav_pkg::SAMPLE_W-1:0]  x_in,
   input  logic signed [tmav_pkg::SAMPLE_W-1:0]  y_in,
   output logic signed [tmav_pkg::SAMPLE_W-1:0]  x_out,
   output logic signed [tmav_pkg::SAMPLE_W-1:0]  y_out
);

   logic signed [tmav_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [tmav_pkg::SAMPLE_W-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (shift) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

// ===== sv/tmav_scale.sv =====
// Per-axis scaling: sum * gain, floor divide by WINDOW * 8192, add offset, saturate.
// Three registered steps driven by a pipe_ctl_type from the top. Depends on tmav_pkg.
`timescale 1ns / 1ps

module tmav_scale (
   input  logic                                clock,
   input  tmav_pkg::pipe_ctl_type              ctl,
   input  logic signed [tmav_pkg::SUM_W-1:0]   sum,
   input  logic [tmav_pkg::GAIN_W-1:0]         gain,
   input  logic [tmav_pkg::OFS_W-1:0]          offset,
   output logic [tmav_pkg::PULSE_W-1:0]        pulse
);

   logic signed [tmav_pkg::PROD_W-1:0]  prod_ff;
   logic signed [tmav_pkg::PROD_W-1:0]  prod_in;
   logic signed [tmav_pkg::PROD_W-1:0]  biased;
   logic [tmav_pkg::U_W-1:0]            u_val;
   logic [tmav_pkg::RPROD_W-1:0]        rprod;
   logic [tmav_pkg::QUOT_W-1:0]         quot_ff;
   logic [tmav_pkg::QUOT_W-1:0]         quot_in;
   logic signed [tmav_pkg::RES_W-1:0]   res;
   logic [tmav_pkg::PULSE_W-1:0]        pulse_ff;
   logic [tmav_pkg::PULSE_W-1:0]        pulse_in;

   assign prod_in = tmav_pkg::PROD_W'(sum) *
                    tmav_pkg::PROD_W'($signed({1'b0, gain}));

   // arithmetic shift floors by 8192; bias makes the remaining divide unsigned
   assign biased  = (prod_ff >>> tmav_pkg::ONE_G_LOG2) +
                    tmav_pkg::PROD_W'(tmav_pkg::BIAS);
   assign u_val   = biased[tmav_pkg::U_W-1:0];
   assign rprod   = tmav_pkg::RPROD_W'(u_val) *
                    tmav_pkg::RPROD_W'(tmav_pkg::RECIP);
   assign quot_in = rprod[tmav_pkg::RECIP_SHIFT +: tmav_pkg::QUOT_W];

   assign res = $signed({2'b00, offset}) + $signed(tmav_pkg::RES_W'(quot_ff)) -
                tmav_pkg::RES_W'(tmav_pkg::QBIAS);

   always_comb begin
      if (res < 0) begin
         pulse_in = '0;
      end else if (res > $signed(tmav_pkg::RES_W'({tmav_pkg::PULSE_W{1'b1}}))) begin
         pulse_in = '1;
      end else begin
         pulse_in = res[tmav_pkg::PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld_quot) begin
         quot_ff <= quot_in;
      end
      if (ctl.ld_out) begin
         pulse_ff <= pulse_in;
      end
   end

   assign pulse = pulse_ff;

endmodule

// ===== sv/tilt_to_servo_moving_average.sv =====
// Top level: tilt samples in, two servo compare values out per beat.
// Instantiates tmav_cell (window chain) and tmav_scale (per axis); uses tmav_pkg.
//
// Usage:
//  - req_ channel: one beat per sample pair, X in tdata[15:0], Y in tdata[31:16].
//  - rsp_ channel: one beat per sample pair, pulse_x in tdata[15:0], pulse_y above.
//  - csr_ port: gain (index 0), x_offset (1), y_offset (2); write only while idle.
//  - Each sample is clamped to +/- 8192 counts and shifted into a chain of 50
//    cells per axis; the running sum adds the new sample and drops the one
//    leaving the last cell. The window starts all zero.
//  - Order: an accepted sample's result shows on rsp_ after the registers for
//    sum update, multiply, reciprocal divide, and offset and saturate.
//  - Throughput: one beat per cycle; every stage has its own valid bit, so a
//    new sample is taken whenever any stage ahead has room.
//  - Stall: when rsp_tready is low the result holds; stages behind fill up and
//    req_tready drops once all four are full.
//  - Reset clears the window, sums and valid bits and restores register defaults.
`timescale 1ns / 1ps

module tilt_to_servo_moving_average (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*tmav_pkg::ACCEL_W-1:0]       req_tdata,  // accel_x, accel_y
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*tmav_pkg::PULSE_W-1:0]       rsp_tdata,  // pulse_x, pulse_y
   input  logic                                 csr_we,
   input  logic [tmav_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [tmav_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int N = tmav_pkg::WINDOW;

   logic [tmav_pkg::GAIN_W-1:0] gain_ff;
   logic [tmav_pkg::OFS_W-1:0]  x_offset_ff;
   logic [tmav_pkg::OFS_W-1:0]  y_offset_ff;

   logic                                 accept;
   logic signed [tmav_pkg::SAMPLE_W-1:0] new_x;
   logic signed [tmav_pkg::SAMPLE_W-1:0] new_y;
   logic signed [tmav_pkg::SAMPLE_W-1:0] cell_x [N];
   logic signed [tmav_pkg::SAMPLE_W-1:0] cell_y [N];
   logic signed [tmav_pkg::SUM_W-1:0]    sum_x_ff;
   logic signed [tmav_pkg::SUM_W-1:0]    sum_y_ff;
   logic signed [tmav_pkg::SUM_W-1:0]    sum_x_in;
   logic signed [tmav_pkg::SUM_W-1:0]    sum_y_in;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdyo;
   tmav_pkg::pipe_ctl_type ctl;
   logic [tmav_pkg::PULSE_W-1:0] pulse_x;
   logic [tmav_pkg::PULSE_W-1:0] pulse_y;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= tmav_pkg::GAIN_RESET;
         x_offset_ff <= tmav_pkg::X_OFFSET_RESET;
         y_offset_ff <= tmav_pkg::Y_OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            tmav_pkg::CSR_GAIN:     gain_ff     <= csr_wdata[tmav_pkg::GAIN_W-1:0];
            tmav_pkg::CSR_X_OFFSET: x_offset_ff <= csr_wdata[tmav_pkg::OFS_W-1:0];
            tmav_pkg::CSR_Y_OFFSET: y_offset_ff <= csr_wdata[tmav_pkg::OFS_W-1:0];
            default: ;
         endcase
      end
   end

   // per-stage handshake
   assign rdyo = !vo_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdyo;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept = req_tvalid && rdy1;

   assign ctl.ld_prod = v1_ff && rdy2;
   assign ctl.ld_quot = v2_ff && rdy3;
   assign ctl.ld_out  = v3_ff && rdyo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdyo) vo_ff <= v3_ff;
      end
   end

   // window chain
   assign new_x = tmav_pkg::clamp_sample(req_tdata[tmav_pkg::ACCEL_W-1:0]);
   assign new_y = tmav_pkg::clamp_sample(req_tdata[2*tmav_pkg::ACCEL_W-1:tmav_pkg::ACCEL_W]);

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
         tmav_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (accept),
            .x_in  (new_x),
            .y_in  (new_y),
            .x_out (cell_x[i]),
            .y_out (cell_y[i])
         );
      end else begin : g_body
         tmav_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (accept),
            .x_in  (cell_x[i-1]),
            .y_in  (cell_y[i-1]),
            .x_out (cell_x[i]),
            .y_out (cell_y[i])
         );
      end
   end

   // running sums: add the new sample, drop the one falling off the tail
   assign sum_x_in = sum_x_ff - tmav_pkg::SUM_W'(cell_x[N-1]) + tmav_pkg::SUM_W'(new_x);
   assign sum_y_in = sum_y_ff - tmav_pkg::SUM_W'(cell_y[N-1]) + tmav_pkg::SUM_W'(new_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (accept) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   tmav_scale u_scale_x (
      .clock  (clock),
      .ctl    (ctl),
      .sum    (sum_x_ff),
      .gain   (gain_ff),
      .offset (x_offset_ff),
      .pulse  (pulse_x)
   );

   tmav_scale u_scale_y (
      .clock  (clock),
      .ctl    (ctl),
      .sum    (sum_y_ff),
      .gain   (gain_ff),
      .offset (y_offset_ff),
      .pulse  (pulse_y)
   );

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {pulse_y, pulse_x};

   // checks
   a_sum_x_range: assert property (@(posedge clock) disable iff (reset)
      (sum_x_ff <= tmav_pkg::SUM_W'(N * tmav_pkg::ONE_G)) &&
      (sum_x_ff >= -tmav_pkg::SUM_W'(N * tmav_pkg::ONE_G)))
      else $error("sum_x outside window bounds");

   a_head_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cell_x[0] == $past(new_x)) && (cell_y[0] == $past(new_y)) && v1_ff)
      else $error("accepted beat did not enter the head cell");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdyo) |=> v3_ff)
      else $error("stage 3 dropped a beat under stall");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && vo_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken with a full pipeline");

endmodule
